FILE: hw/rtl/tssq_pkg.sv
// ----------------------------------------------------------------------------
// tssq_pkg: shared types and constants of the time-sync request sequencer
// Sequencer states, register indexes, reset values, divide constants and
// the structs that travel between the time-split pipeline and the top level.
// ----------------------------------------------------------------------------
package tssq_pkg;

	// default width of the tick counter and the deadlines
	localparam int TICK_WIDTH_DEF = 32;

	// sequencer states, codes as seen on fsm_state
	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_CRON      = 3'd1,
		ST_REQUEST   = 3'd2,
		ST_RESPONSE  = 3'd3,
		ST_COMPLETED = 3'd4,
		ST_ONESHOT   = 3'd5
	} state_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_CRON_MINUTE      = 3'd0,
		CFG_AUTO_RETRIES     = 3'd1,
		CFG_MANUAL_RETRIES   = 3'd2,
		CFG_RESPONSE_TIMEOUT = 3'd3,
		CFG_GUARD_TIME       = 3'd4
	} cfg_idx_t;

	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic [5:0]  RST_CRON_MINUTE      = 6'd58;
	localparam logic [5:0]  RST_AUTO_RETRIES     = 6'd30;
	localparam logic [5:0]  RST_MANUAL_RETRIES   = 6'd4;
	localparam logic [7:0]  RST_RESPONSE_TIMEOUT = 8'd10;
	localparam logic [15:0] RST_GUARD_TIME       = 16'(15 * 60);

	// time constants
	localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

	// reciprocal multipliers
	// x / 225 for x < 2^28: (x * DIV225_MUL) >> 36 gives the quotient or one less
	localparam logic [28:0] DIV225_MUL = 29'd305419896;
	// z / 15 for z < 900: (z * DIV15_MUL) >> 14, exact
	localparam logic [10:0] DIV15_MUL  = 11'd1093;
	// y / 3 for y < 2^18: (y * DIV3_MUL) >> 20, exact
	localparam logic [18:0] DIV3_MUL   = 19'd349526;

	// one input item
	typedef struct packed {
		logic        mode;
		logic [31:0] now_tick;
		logic [5:0]  clock_minutes;
		logic [5:0]  clock_seconds;
		logic        link_up;
		logic        response_valid;
		logic [31:0] response_time;
	} item_t;

	// fields the sequencer uses directly
	typedef struct packed {
		logic        mode;
		logic [31:0] now_tick;
		logic [5:0]  clock_minutes;
		logic        link_up;
		logic        response_valid;
	} ctl_t;

	// server time split into hour, minute, second and offset
	typedef struct packed {
		logic [4:0]         hours;
		logic [5:0]         minutes;
		logic [5:0]         seconds;
		logic signed [12:0] delta;
	} tsplit_t;

endpackage

FILE: hw/rtl/tssq_split.sv
// ----------------------------------------------------------------------------
// tssq_split: server time split pipeline
// Six-stage elastic pipeline: registers the input item, splits the server
// time into hour of day, minute and second and forms the in-hour offset.
// ----------------------------------------------------------------------------
module tssq_split (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tssq_pkg::item_t   in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output tssq_pkg::ctl_t    out_ctl,
	output tssq_pkg::tsplit_t out_time
);

	localparam int NSTAGE = 6;

	logic [NSTAGE-1:0] vld_q;
	logic [NSTAGE:0]   rdy;

	// stage registers
	tssq_pkg::item_t   item_s1;
	tssq_pkg::ctl_t    ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic [31:0]       rt_s2;
	logic [20:0]       qe_s2, qe_s3, q_s4;
	logic [11:0]       loc_s2, loc_s3, loc_s4, loc_s5;
	logic [12:0]       rraw_s3;
	logic [11:0]       rem_s4, rem_s5;
	logic [5:0]        min_s5;
	logic [2:0]        qlo_s5;
	logic [17:0]       y_s5;
	logic [16:0]       y3_s5;
	tssq_pkg::tsplit_t time_s6;

	// stage logic
	logic [56:0]       hq_prod;
	logic [11:0]       loc_c;
	logic [12:0]       rraw_c;
	logic [19:0]       mq_prod;
	logic [36:0]       y3_prod;
	logic [1:0]        hmod_c;
	tssq_pkg::tsplit_t time_c;

	// ready chain: a stage takes new data when empty or when it moves on
	always_comb begin
		rdy[NSTAGE] = out_ready;
		for (int i = NSTAGE - 1; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[NSTAGE-1];
	assign out_ctl   = ctl_s6;
	assign out_time  = time_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NSTAGE; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// stage 2: hour estimate from the server time, local seconds in hour
	assign hq_prod = 57'(item_s1.response_time[31:4]) * 57'(tssq_pkg::DIV225_MUL);
	assign loc_c   = 12'(item_s1.clock_minutes) * 12'(tssq_pkg::SEC_PER_MIN)
	               + 12'(item_s1.clock_seconds);

	// stage 3: raw remainder, below two hours
	assign rraw_c = 13'(rt_s2 - 32'(qe_s2) * 32'(tssq_pkg::SEC_PER_HOUR));

	// stage 5: minute and hours-div-24 quotients
	assign mq_prod = 20'(rem_s4[11:2]) * 20'(tssq_pkg::DIV15_MUL);
	assign y3_prod = 37'(q_s4[20:3]) * 37'(tssq_pkg::DIV3_MUL);

	// stage 6: second, hour of day and offset
	always_comb begin
		hmod_c         = 2'(y_s5 - 18'(y3_s5) * 18'd3);
		time_c.hours   = {hmod_c, qlo_s5};
		time_c.minutes = min_s5;
		time_c.seconds = 6'(rem_s5 - 12'(min_s5) * 12'(tssq_pkg::SEC_PER_MIN));
		time_c.delta   = $signed({1'b0, rem_s5}) - $signed({1'b0, loc_s5});
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			item_s1 <= in_item;
		end
		if (rdy[1]) begin
			ctl_s2.mode           <= item_s1.mode;
			ctl_s2.now_tick       <= item_s1.now_tick;
			ctl_s2.clock_minutes  <= item_s1.clock_minutes;
			ctl_s2.link_up        <= item_s1.link_up;
			ctl_s2.response_valid <= item_s1.response_valid;
			rt_s2                 <= item_s1.response_time;
			qe_s2                 <= hq_prod[56:36];
			loc_s2                <= loc_c;
		end
		if (rdy[2]) begin
			ctl_s3  <= ctl_s2;
			rraw_s3 <= rraw_c;
			qe_s3   <= qe_s2;
			loc_s3  <= loc_s2;
		end
		// stage 4: correct the hour estimate by one
		if (rdy[3]) begin
			ctl_s4 <= ctl_s3;
			loc_s4 <= loc_s3;
			if (rraw_s3 >= 13'(tssq_pkg::SEC_PER_HOUR)) begin
				rem_s4 <= 12'(rraw_s3 - 13'(tssq_pkg::SEC_PER_HOUR));
				q_s4   <= qe_s3 + 21'd1;
			end else begin
				rem_s4 <= rraw_s3[11:0];
				q_s4   <= qe_s3;
			end
		end
		if (rdy[4]) begin
			ctl_s5 <= ctl_s4;
			loc_s5 <= loc_s4;
			rem_s5 <= rem_s4;
			min_s5 <= mq_prod[19:14];
			qlo_s5 <= q_s4[2:0];
			y_s5   <= q_s4[20:3];
			y3_s5  <= y3_prod[36:20];
		end
		if (rdy[5]) begin
			ctl_s6  <= ctl_s5;
			time_s6 <= time_c;
		end
	end

endmodule

FILE: hw/rtl/time_sync_request_sequencer.sv
// ----------------------------------------------------------------------------
// time_sync_request_sequencer: time-sync client sequencer
// Each input transfer is one service tick; each tick gives one result transfer.
//
// Channels: input and result use valid/stall; a transfer happens on a clock
// edge with valid high and stall low. Configuration is a plain write port
// (cfg_write, cfg_index, cfg_data); the user must write it only while the
// block is idle; the block itself does not enforce this. Path: an input
// transfer loads the first of six split stages, the tick moves on to the
// last one, and the sequencer step loads the result register from it.
// Throughput: one tick per cycle unless the result stalls; the state is
// updated in the same cycle in which a tick moves from the split pipeline
// into the result register, so consecutive ticks see each other's updates.
// Reset: state goes to idle, counters, deadlines and drift sum to zero,
// registers to their default values; no pipeline stage holds a tick.
// Stall: a stalled result holds; the pipeline fills behind it and in_stall
// rises once all stages are full.
// ----------------------------------------------------------------------------
module time_sync_request_sequencer #(
	parameter int TICK_WIDTH = tssq_pkg::TICK_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                mode,
	input  logic [31:0]         now_tick,
	input  logic [5:0]          clock_minutes,
	input  logic [5:0]          clock_seconds,
	input  logic                link_up,
	input  logic                response_valid,
	input  logic [31:0]         response_time,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          fsm_state,
	output logic                send_request,
	output logic                set_clock,
	output logic [4:0]          new_hours,
	output logic [5:0]          new_minutes,
	output logic [5:0]          new_seconds,
	output logic signed [12:0]  adjust_delta,
	output logic signed [31:0]  total_drift,
	output logic                drift_updated
);

	// configuration registers
	logic [5:0]  cron_minute_q;
	logic [5:0]  auto_retries_q;
	logic [5:0]  manual_retries_q;
	logic [7:0]  response_timeout_q;
	logic [15:0] guard_time_q;

	// sequencer state
	tssq_pkg::state_t        state_q, state_d;
	logic [5:0]              retries_q, retries_d;
	logic [TICK_WIDTH-1:0]   resp_dl_q, resp_dl_d;
	logic [TICK_WIDTH-1:0]   guard_dl_q, guard_dl_d;
	logic                    synced_q, synced_d;
	logic signed [31:0]      drift_q, drift_d;

	// split pipeline interface
	tssq_pkg::item_t         in_item;
	logic                    sp_in_ready;
	logic                    sp_valid;
	logic                    sp_ready;
	tssq_pkg::ctl_t          sp_ctl;
	tssq_pkg::tsplit_t       sp_time;

	// step logic
	logic                    out_ready;
	logic                    step;
	logic [TICK_WIDTH-1:0]   now_w;
	logic [TICK_WIDTH-1:0]   resp_diff;
	logic [TICK_WIDTH-1:0]   guard_diff;
	logic                    resp_expired;
	logic                    guard_expired;
	logic                    send_c;
	logic                    apply_c;
	logic                    dupd_c;
	logic signed [32:0]      drift_sum;

	// result register
	logic                    out_valid_q;
	logic [2:0]              fsm_state_q;
	logic                    send_q;
	logic                    setc_q;
	logic [4:0]              hours_q;
	logic [5:0]              minutes_q;
	logic [5:0]              seconds_q;
	logic signed [12:0]      delta_q;
	logic signed [31:0]      total_drift_q;
	logic                    dupd_q;

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cron_minute_q      <= tssq_pkg::RST_CRON_MINUTE;
			auto_retries_q     <= tssq_pkg::RST_AUTO_RETRIES;
			manual_retries_q   <= tssq_pkg::RST_MANUAL_RETRIES;
			response_timeout_q <= tssq_pkg::RST_RESPONSE_TIMEOUT;
			guard_time_q       <= tssq_pkg::RST_GUARD_TIME;
		end else if (cfg_write) begin
			case (tssq_pkg::cfg_idx_t'(cfg_index))
				tssq_pkg::CFG_CRON_MINUTE:      cron_minute_q      <= cfg_data[5:0];
				tssq_pkg::CFG_AUTO_RETRIES:     auto_retries_q     <= cfg_data[5:0];
				tssq_pkg::CFG_MANUAL_RETRIES:   manual_retries_q   <= cfg_data[5:0];
				tssq_pkg::CFG_RESPONSE_TIMEOUT: response_timeout_q <= cfg_data[7:0];
				tssq_pkg::CFG_GUARD_TIME:       guard_time_q       <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// input item into the split pipeline
	always_comb begin
		in_item.mode           = mode;
		in_item.now_tick       = now_tick;
		in_item.clock_minutes  = clock_minutes;
		in_item.clock_seconds  = clock_seconds;
		in_item.link_up        = link_up;
		in_item.response_valid = response_valid;
		in_item.response_time  = response_time;
	end

	assign in_stall = !sp_in_ready;

	tssq_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (sp_in_ready),
		.in_item   (in_item),
		.out_valid (sp_valid),
		.out_ready (sp_ready),
		.out_ctl   (sp_ctl),
		.out_time  (sp_time)
	);

	// a tick steps the sequencer when the result register can take it
	assign out_ready = !out_valid_q || !out_stall;
	assign sp_ready  = out_ready;
	assign step      = sp_valid && out_ready;

	// deadline tests: expired once now is at or past the deadline
	assign now_w         = TICK_WIDTH'(sp_ctl.now_tick);
	assign resp_diff     = now_w - resp_dl_q;
	assign guard_diff    = now_w - guard_dl_q;
	assign resp_expired  = !resp_diff[TICK_WIDTH-1];
	assign guard_expired = !guard_diff[TICK_WIDTH-1];

	// step outputs
	always_comb begin
		send_c  = !sp_ctl.mode && (state_q == tssq_pkg::ST_REQUEST) && sp_ctl.link_up;
		apply_c = !sp_ctl.mode && (state_q == tssq_pkg::ST_RESPONSE) && !resp_expired
		        && sp_ctl.response_valid;
		dupd_c  = apply_c && synced_q;
	end

	// saturating drift accumulate
	always_comb begin
		drift_sum = 33'(drift_q) + 33'(sp_time.delta);
		if (drift_sum > 33'sd2147483647) begin
			drift_d = 32'sh7FFF_FFFF;
		end else if (drift_sum < -33'sd2147483648) begin
			drift_d = 32'sh8000_0000;
		end else begin
			drift_d = drift_sum[31:0];
		end
		if (!dupd_c) begin
			drift_d = drift_q;
		end
	end

	// next state
	always_comb begin
		state_d    = state_q;
		retries_d  = retries_q;
		resp_dl_d  = resp_dl_q;
		guard_dl_d = guard_dl_q;
		synced_d   = synced_q;
		if (sp_ctl.mode) begin
			state_d = tssq_pkg::ST_ONESHOT;
		end else begin
			case (state_q)
				tssq_pkg::ST_CRON: begin
					guard_dl_d = now_w + TICK_WIDTH'(guard_time_q);
					retries_d  = auto_retries_q;
					state_d    = tssq_pkg::ST_REQUEST;
				end
				tssq_pkg::ST_ONESHOT: begin
					retries_d = manual_retries_q;
					state_d   = tssq_pkg::ST_REQUEST;
				end
				tssq_pkg::ST_REQUEST: begin
					if (sp_ctl.link_up) begin
						resp_dl_d = now_w + TICK_WIDTH'(response_timeout_q);
						state_d   = tssq_pkg::ST_RESPONSE;
					end
				end
				tssq_pkg::ST_RESPONSE: begin
					// timeout wins over a response in the same tick
					if (resp_expired) begin
						if (retries_q == '0) begin
							state_d = tssq_pkg::ST_COMPLETED;
						end else begin
							retries_d = retries_q - 6'd1;
							state_d   = tssq_pkg::ST_REQUEST;
						end
					end else if (sp_ctl.response_valid) begin
						synced_d = 1'b1;
						state_d  = tssq_pkg::ST_COMPLETED;
					end
				end
				tssq_pkg::ST_COMPLETED: begin
					if (guard_expired) begin
						state_d = tssq_pkg::ST_IDLE;
					end
				end
				default: begin
					state_d = (sp_ctl.clock_minutes == cron_minute_q) ?
					          tssq_pkg::ST_CRON : tssq_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// sequencer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tssq_pkg::ST_IDLE;
			retries_q  <= '0;
			resp_dl_q  <= '0;
			guard_dl_q <= '0;
			synced_q   <= 1'b0;
			drift_q    <= '0;
		end else if (step) begin
			state_q    <= state_d;
			retries_q  <= retries_d;
			resp_dl_q  <= resp_dl_d;
			guard_dl_q <= guard_dl_d;
			synced_q   <= synced_d;
			drift_q    <= drift_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= sp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			fsm_state_q   <= state_d;
			send_q        <= send_c;
			setc_q        <= apply_c;
			hours_q       <= apply_c ? sp_time.hours   : '0;
			minutes_q     <= apply_c ? sp_time.minutes : '0;
			seconds_q     <= apply_c ? sp_time.seconds : '0;
			delta_q       <= apply_c ? sp_time.delta   : '0;
			total_drift_q <= drift_d;
			dupd_q        <= dupd_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign fsm_state     = fsm_state_q;
	assign send_request  = send_q;
	assign set_clock     = setc_q;
	assign new_hours     = hours_q;
	assign new_minutes   = minutes_q;
	assign new_seconds   = seconds_q;
	assign adjust_delta  = delta_q;
	assign total_drift   = total_drift_q;
	assign drift_updated = dupd_q;

`ifndef SYNTHESIS
	// an applied response always ends in completed
	a_setc_completed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && set_clock |-> fsm_state == tssq_pkg::ST_COMPLETED)
		else $error("set_clock outside completed state");

	// drift only accumulates on an applied response
	a_dupd_setc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drift_updated |-> set_clock)
		else $error("drift update without clock set");

	// a request is always followed by waiting for its response
	a_send_response: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_request |-> fsm_state == tssq_pkg::ST_RESPONSE)
		else $error("send_request outside response state");

	// the drift sum moves only with a reported update
	a_drift_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && !dupd_c |=> $stable(drift_q))
		else $error("drift sum changed without update");
`endif

endmodule
